// ===== hw/rtl/ctmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ctmt_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int US_PER_MS   = 1000;
    localparam int DIV_DIGITS  = 12;

    localparam logic [31:0] REPORT_TIMEOUT_RST = 32'd25000;
    localparam logic [31:0] SLOW_WARN_RST      = 32'd1000;
    localparam logic [15:0] AGENT_LIMIT_RST    = 16'd250;
    localparam logic [5:0]  CAPACITY_RST       = 6'd32;

    // input kinds
    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_END   = 3'd1;
    localparam logic [2:0] K_AGENT = 3'd2;
    localparam logic [2:0] K_TICK  = 3'd3;
    localparam logic [2:0] K_QUERY = 3'd4;

    // result kinds
    localparam logic [3:0] R_RESTARTED  = 4'd0;
    localparam logic [3:0] R_ADDED      = 4'd1;
    localparam logic [3:0] R_FULL       = 4'd2;
    localparam logic [3:0] R_ENDED      = 4'd3;
    localparam logic [3:0] R_END_MISS   = 4'd4;
    localparam logic [3:0] R_AGENT_OK   = 4'd5;
    localparam logic [3:0] R_AGENT_MISS = 4'd6;
    localparam logic [3:0] R_QUERY      = 4'd7;
    localparam logic [3:0] R_FREED      = 4'd8;
    localparam logic [3:0] R_TIMEOUT    = 4'd9;
    localparam logic [3:0] R_SLOW       = 4'd10;
    localparam logic [3:0] R_TICK_DONE  = 4'd11;

    // register indexes
    localparam logic [1:0] CFG_REPORT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_SLOW_WARN      = 2'd1;
    localparam logic [1:0] CFG_AGENT_LIMIT    = 2'd2;
    localparam logic [1:0] CFG_CAPACITY       = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] process_id;
        logic [15:0] thread_id;
        logic [31:0] command_id;
        logic [47:0] now_us;
    } item_t;

    typedef struct packed {
        logic [3:0]  result_kind;
        logic [15:0] out_process_id;
        logic [15:0] out_thread_id;
        logic [31:0] last_command;
        logic [15:0] command_count;
        logic [15:0] agent_calls;
        logic [38:0] elapsed_ms;
        logic [47:0] total_us;
        logic        is_reported;
        logic [5:0]  entries_used;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] process;
        logic [15:0] thread;
        logic [47:0] start_time;
        logic [15:0] count;
        logic        reported;
        logic [31:0] command;
        logic [47:0] total;
        logic [15:0] agent;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CNT, S_RD, S_CHK, S_MISS, S_UPD, S_ALLOC,
        S_DIVS, S_DIVW, S_TDEC, S_TDONE
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       idx_clr;
        logic       idx_inc;
        logic       cnt_step;
        logic       occ_tick;
        logic       chk_free;
        logic       rec_load;
        logic       upd;
        logic       alloc;
        logic       div_start;
        logic       tick_free;
        logic       tick_rep;
        logic       emit;
        logic       emit_plain;
        logic       emit_last;
        logic [3:0] emit_kind;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       idx_last;
        logic       slot_valid;
        logic       match;
        logic       can_alloc;
        logic       alloc_done;
        logic       div_busy;
        logic       returned;
        logic       timeout_new;
        logic       slow;
    } ctrl_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ctmt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctmt_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    output logic             busy,
    output logic [38:0]      quotient
);
    import ctmt_pkg::*;

    logic [3:0]  cnt_reg, cnt_next;
    logic [9:0]  rem_reg, rem_next;
    logic [47:0] dvd_reg, dvd_next;
    logic [47:0] quo_reg, quo_next;
    logic [13:0] v;
    logic [3:0]  digit;

    // radix-16 long division by the constant, one digit a cycle
    always_comb
    begin
        v     = {rem_reg, dvd_reg[47:44]};
        digit = 4'd0;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= 14'(k * US_PER_MS))
                digit = 4'(k);
        end
        rem_next = 10'(v - 14'(digit) * 14'(US_PER_MS));
        dvd_next = {dvd_reg[43:0], 4'd0};
        quo_next = {quo_reg[43:0], digit};
        cnt_next = cnt_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 4'd0;
        else if (start)
            cnt_reg <= 4'(DIV_DIGITS);
        else if (cnt_reg != 4'd0)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 10'd0;
            dvd_reg <= dividend;
            quo_reg <= 48'd0;
        end
        else if (cnt_reg != 4'd0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (cnt_reg != 4'd0);
    assign quotient = quo_reg[38:0];

endmodule
`default_nettype wire

// ===== hw/rtl/ctmt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctmt_datapath #(
    parameter int ENTRIES = ctmt_pkg::ENTRIES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  ctmt_pkg::item_t          item,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [31:0]         cfg_wdata,
    input  ctmt_pkg::ctrl_cmd_t      cmd,
    output ctmt_pkg::ctrl_sts_t      sts,
    output logic                     result_valid,
    output ctmt_pkg::result_t        result
);
    import ctmt_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);

    entry_t              mem [ENTRIES];
    entry_t              rd_data;
    entry_t              rec_reg, rec_upd, rec_new, rec_rep, mem_wd;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;

    item_t               item_reg;
    logic [IW-1:0]       idx_reg, free_reg;
    logic                free_found_reg, alloc_reg;
    logic [ENTRIES-1:0]  valid_reg, ret_reg;
    logic [OW-1:0]       occ_reg, cnt_reg, cnt_sum;
    logic [31:0]         timeout_reg, slow_reg;
    logic [15:0]         limit_reg;
    logic [5:0]          cap_reg, cap_eff;
    logic                out_valid_reg;
    result_t             out_reg, res_next;

    logic                div_busy;
    logic [38:0]         ms;
    logic [47:0]         el_us;
    logic [48:0]         sum49;
    logic                pt_eq, match;

    ctmt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (item_reg.now_us - rec_reg.start_time),
        .busy     (div_busy),
        .quotient (ms)
    );

    always_comb
    begin
        pt_eq = (rd_data.process == item_reg.process_id) &&
                (rd_data.thread == item_reg.thread_id);
        case (item_reg.kind)
            K_QUERY: match = valid_reg[idx_reg] && (rd_data.thread == item_reg.thread_id);
            K_END:   match = valid_reg[idx_reg] && pt_eq && !ret_reg[idx_reg];
            default: match = valid_reg[idx_reg] && pt_eq;
        endcase
    end

    // updated entry on a hit, new entry on an allocation, reported entry on a tick timeout, and the memory write port
    always_comb
    begin
        el_us   = item_reg.now_us - rec_reg.start_time;
        sum49   = {1'b0, rec_reg.total} + {1'b0, el_us};
        rec_upd = rec_reg;
        case (item_reg.kind)
            K_START:
            begin
                rec_upd.start_time = item_reg.now_us;
                if (rec_reg.count != 16'hFFFF)
                    rec_upd.count = rec_reg.count + 16'd1;
                rec_upd.reported = 1'b0;
                rec_upd.command  = item_reg.command_id;
                rec_upd.agent    = 16'd0;
            end
            K_END:
                rec_upd.total = sum49[48] ? 48'hFFFF_FFFF_FFFF : sum49[47:0];
            K_AGENT:
            begin
                rec_upd.start_time = item_reg.now_us;
                if (rec_reg.agent != 16'hFFFF)
                    rec_upd.agent = rec_reg.agent + 16'd1;
            end
            default: rec_upd = rec_reg;
        endcase
        rec_new            = '0;
        rec_new.process    = item_reg.process_id;
        rec_new.thread     = item_reg.thread_id;
        rec_new.start_time = item_reg.now_us;
        rec_new.count      = 16'd1;
        rec_new.command    = item_reg.command_id;
        rec_rep            = rec_reg;
        rec_rep.reported   = 1'b1;
        mem_we = cmd.upd || cmd.alloc || cmd.tick_rep;
        mem_wa = cmd.alloc ? free_reg : idx_reg;
        mem_wd = cmd.alloc ? rec_new : (cmd.upd ? rec_upd : rec_rep);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data <= mem[idx_reg];
    end

    assign cap_eff = (cap_reg > 6'(ENTRIES)) ? 6'(ENTRIES) : cap_reg;
    assign cnt_sum = cnt_reg + OW'(valid_reg[idx_reg] & ret_reg[idx_reg]);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            occ_reg        <= '0;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            alloc_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= REPORT_TIMEOUT_RST;
            slow_reg       <= SLOW_WARN_RST;
            limit_reg      <= AGENT_LIMIT_RST;
            cap_reg        <= CAPACITY_RST;
        end
        else
        begin
            out_valid_reg <= cmd.emit;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_REPORT_TIMEOUT: timeout_reg <= cfg_wdata;
                    CFG_SLOW_WARN:      slow_reg    <= cfg_wdata;
                    CFG_AGENT_LIMIT:    limit_reg   <= cfg_wdata[15:0];
                    CFG_CAPACITY:       cap_reg     <= cfg_wdata[5:0];
                endcase
            end
            if (cmd.load_item)
            begin
                cnt_reg        <= '0;
                free_found_reg <= 1'b0;
                alloc_reg      <= 1'b0;
            end
            if (cmd.cnt_step)
                cnt_reg <= cnt_sum;
            // tick frees are settled up front so every result shows the final count
            if (cmd.occ_tick)
                occ_reg <= occ_reg - cnt_sum;
            if (cmd.chk_free && !valid_reg[idx_reg] && !free_found_reg)
                free_found_reg <= 1'b1;
            if (cmd.alloc)
            begin
                valid_reg[free_reg] <= 1'b1;
                occ_reg             <= occ_reg + OW'(1);
                alloc_reg           <= 1'b1;
            end
            if (cmd.tick_free)
                valid_reg[idx_reg] <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;
        if (cmd.idx_clr)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + IW'(1);
        if (cmd.chk_free && !valid_reg[idx_reg] && !free_found_reg)
            free_reg <= idx_reg;
        if (cmd.rec_load)
            rec_reg <= rd_data;
        else if (cmd.upd)
            rec_reg <= rec_upd;
        else if (cmd.alloc)
            rec_reg <= rec_new;
        // an agent call leaves the returned mark alone
        if (cmd.upd)
        begin
            if (item_reg.kind == K_END)
                ret_reg[idx_reg] <= 1'b1;
            else if (item_reg.kind == K_START)
                ret_reg[idx_reg] <= 1'b0;
        end
        if (cmd.alloc)
            ret_reg[free_reg] <= 1'b0;
        if (cmd.emit)
            out_reg <= res_next;
    end

    always_comb
    begin
        res_next              = '0;
        res_next.result_kind  = cmd.emit_kind;
        res_next.entries_used = 6'(occ_reg);
        res_next.last         = cmd.emit_last;
        if (cmd.emit_plain)
        begin
            if (cmd.emit_kind != R_QUERY && cmd.emit_kind != R_TICK_DONE)
                res_next.out_process_id = item_reg.process_id;
            if (cmd.emit_kind != R_TICK_DONE)
                res_next.out_thread_id = item_reg.thread_id;
        end
        else
        begin
            res_next.out_process_id = rec_reg.process;
            res_next.out_thread_id  = rec_reg.thread;
            res_next.last_command   = rec_reg.command;
            res_next.command_count  = rec_reg.count;
            res_next.agent_calls    = rec_reg.agent;
            res_next.elapsed_ms     = ms;
            res_next.total_us       = rec_reg.total;
            res_next.is_reported    = (cmd.emit_kind == R_QUERY) &&
                                      (rec_reg.reported || rec_reg.agent > limit_reg);
        end
    end

    always_comb
    begin
        sts             = '0;
        sts.kind        = item_reg.kind;
        sts.idx_last    = (idx_reg == IW'(ENTRIES - 1));
        sts.slot_valid  = valid_reg[idx_reg];
        sts.match       = match;
        sts.can_alloc   = free_found_reg && (6'(occ_reg) < cap_eff);
        sts.alloc_done  = alloc_reg;
        sts.div_busy    = div_busy;
        sts.returned    = ret_reg[idx_reg];
        sts.timeout_new = (ms > {7'd0, timeout_reg}) && !rec_reg.reported;
        sts.slow        = (ms > {7'd0, slow_reg});
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/ctmt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctmt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [2:0]     start_kind,
    input  ctmt_pkg::ctrl_sts_t sts,
    output ctmt_pkg::ctrl_cmd_t cmd,
    output logic                busy
);
    import ctmt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    if (start_kind == K_TICK)
                        state_next = S_CNT;
                    else if (start_kind == K_START || start_kind == K_END ||
                             start_kind == K_AGENT || start_kind == K_QUERY)
                        state_next = S_RD;
                end
            end
            S_CNT:
            begin
                cmd.cnt_step = 1'b1;
                if (sts.idx_last)
                begin
                    cmd.occ_tick = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = S_RD;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (sts.kind == K_TICK)
                begin
                    if (sts.slot_valid)
                    begin
                        cmd.rec_load = 1'b1;
                        state_next   = S_DIVS;
                    end
                    else if (sts.idx_last)
                        state_next = S_TDONE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
                else
                begin
                    cmd.chk_free = 1'b1;
                    if (sts.match)
                    begin
                        cmd.rec_load = 1'b1;
                        state_next   = (sts.kind == K_QUERY) ? S_DIVS : S_UPD;
                    end
                    else if (sts.idx_last)
                        state_next = S_MISS;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_MISS:
            begin
                if (sts.kind == K_START && sts.can_alloc)
                    state_next = S_ALLOC;
                else
                begin
                    cmd.emit       = 1'b1;
                    cmd.emit_plain = 1'b1;
                    cmd.emit_last  = 1'b1;
                    case (sts.kind)
                        K_START: cmd.emit_kind = R_FULL;
                        K_END:   cmd.emit_kind = R_END_MISS;
                        K_AGENT: cmd.emit_kind = R_AGENT_MISS;
                        default: cmd.emit_kind = R_QUERY;
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_DIVS;
            end
            S_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
            begin
                if (!sts.div_busy)
                begin
                    if (sts.kind == K_TICK)
                        state_next = S_TDEC;
                    else
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        case (sts.kind)
                            K_START: cmd.emit_kind = sts.alloc_done ? R_ADDED : R_RESTARTED;
                            K_END:   cmd.emit_kind = R_ENDED;
                            K_AGENT: cmd.emit_kind = R_AGENT_OK;
                            default: cmd.emit_kind = R_QUERY;
                        endcase
                        state_next = S_IDLE;
                    end
                end
            end
            S_TDEC:
            begin
                if (sts.returned)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = R_FREED;
                    cmd.tick_free = 1'b1;
                end
                else if (sts.timeout_new)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = R_TIMEOUT;
                    cmd.tick_rep  = 1'b1;
                end
                else if (sts.slow)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = R_SLOW;
                end
                if (sts.idx_last)
                    state_next = S_TDONE;
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_RD;
                end
            end
            S_TDONE:
            begin
                cmd.emit       = 1'b1;
                cmd.emit_plain = 1'b1;
                cmd.emit_last  = 1'b1;
                cmd.emit_kind  = R_TICK_DONE;
                state_next     = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/command_timeout_monitor_table_core.sv =====
// Watchdog table of per-thread commands. A word is taken when start is high and busy is low;
// busy then stays high until the item's last result appears. Results appear on
// result for one cycle each, flagged by result_valid, and cannot be held off, so the
// receiver must take every word as it comes; the last word of an item has result.last set.
// Each item walks the table one slot at a time through the single read port of the
// entry memory, and each result that reports an entry waits for the divider that turns
// microseconds into milliseconds.
// Configuration may be written only while busy is low and no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module command_timeout_monitor_table_core #(
    parameter int ENTRIES = ctmt_pkg::ENTRIES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  ctmt_pkg::item_t    item,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata,
    output logic               result_valid,
    output ctmt_pkg::result_t  result
);
    import ctmt_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ctmt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_kind (item.kind),
        .sts        (sts),
        .cmd        (cmd),
        .busy       (busy)
    );

    ctmt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire
